### rtl/swarm_gradient_edge_controller_assert.svh
// ----------------------------------------------------------------------------
// Swarm gradient edge controller assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SWARM_GRADIENT_EDGE_CONTROLLER_ASSERT_SVH
`define SWARM_GRADIENT_EDGE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clock, off during reset
`define SGEC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sgec assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SGEC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sgec assertion failed");

`else

`define SGEC_ASSERT_SAME(lbl, ante, cons)
`define SGEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/sgec_pkg.sv
// ----------------------------------------------------------------------------
// sgec_pkg
// Shared types, register indexes, command codes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sgec_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 8;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_IS_SEED          = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ROUND_LENGTH     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_NEIGHBOUR_RANGE  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_NEAR_LIMIT       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ORBIT_RADIUS     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_SILENCE_TIMEOUT  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_EDGE_ROUNDS      = 3'd6;

   // motion commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_STOP    = 3'd1;
   localparam logic [2:0] CMD_FORWARD = 3'd2;
   localparam logic [2:0] CMD_LEFT    = 3'd3;
   localparam logic [2:0] CMD_RIGHT   = 3'd4;

   // LED colors, bit2 red, bit1 green, bit0 blue
   localparam logic [2:0] LED_OFF    = 3'd0;
   localparam logic [2:0] LED_BLUE   = 3'd1;
   localparam logic [2:0] LED_GREEN  = 3'd2;
   localparam logic [2:0] LED_RED    = 3'd4;
   localparam logic [2:0] LED_YELLOW = 3'd6;

   // item kinds
   localparam logic FUNC_MESSAGE = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   localparam logic [7:0] FAR_DISTANCE  = 8'd200;
   localparam logic [7:0] GRADIENT_MAX  = 8'd255;
   localparam logic [6:0] SILENCE_MAX   = 7'd127;
   localparam logic [7:0] EDGE_MAX      = 8'd255;

   // register reset values
   localparam logic       RST_IS_SEED          = 1'b0;
   localparam logic [7:0] RST_ROUND_LENGTH     = 8'd8;
   localparam logic [7:0] RST_NEIGHBOUR_RANGE  = 8'd60;
   localparam logic [7:0] RST_NEAR_LIMIT       = 8'd30;
   localparam logic [7:0] RST_ORBIT_RADIUS     = 8'd50;
   localparam logic [6:0] RST_SILENCE_TIMEOUT  = 7'd64;
   localparam logic [7:0] RST_EDGE_ROUNDS      = 8'd32;

   typedef struct packed {
      logic       is_seed;
      logic [7:0] round_length;
      logic [7:0] neighbour_range;
      logic [7:0] near_limit;
      logic [7:0] orbit_radius;
      logic [6:0] silence_timeout;
      logic [7:0] edge_rounds;
   } cfg_type;

   typedef struct packed {
      logic [7:0] message_count;
      logic [7:0] min_gradient;
      logic [7:0] max_gradient;
      logic [7:0] nearest;
      logic [7:0] own_gradient;
      logic [7:0] edge_count;
      logic       moving;
      logic [6:0] silence_ticks;
   } state_type;

   typedef struct packed {
      logic [7:0] gradient;
      logic       moving;
      logic [2:0] motion_cmd;
      logic [2:0] led_color;
   } result_type;

   function automatic logic [2:0] orbit_cmd(input logic [7:0] d,
                                            input logic [7:0] near_limit,
                                            input logic [7:0] desired);
      logic [2:0] cmd;
      if (d < near_limit)     cmd = CMD_FORWARD;
      else if (d > desired)   cmd = CMD_RIGHT;
      else if (d < desired)   cmd = CMD_LEFT;
      else                    cmd = CMD_FORWARD;
      return cmd;
   endfunction

   function automatic logic [2:0] gradient_color(input logic [7:0] g);
      logic [2:0] c;
      case (g)
         8'd0:    c = LED_GREEN;
         8'd1:    c = LED_YELLOW;
         8'd2:    c = LED_BLUE;
         8'd3:    c = LED_RED;
         default: c = LED_OFF;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/swarm_gradient_edge_controller.sv
// A transaction accepted on req is captured in the input register, then in the
// result register, from which it is presented on rsp.
// Throughput: one transaction per cycle; the input register and the result
// register run as a two-stage pipeline, so req is stalled only while a
// result is held by rsp_stall and the input register is occupied.
// Reset: synchronous, active high; clears the pipeline, loads register
// defaults and the node state (gradient 255, counters zero, not moving).
`default_nettype none

`include "swarm_gradient_edge_controller_assert.svh"

module swarm_gradient_edge_controller
   import sgec_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input items
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_func,
   input  wire logic [7:0]               req_neighbour_gradient,
   input  wire logic [7:0]               req_distance_mm,
   // results
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [7:0]               rsp_gradient,
   output      logic                     rsp_moving,
   output      logic [2:0]               rsp_motion_cmd,
   output      logic [2:0]               rsp_led_color,
   // configuration
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type out_ff;
   logic       core_moving;

   logic       in_vld_ff, in_vld_in;
   logic       in_func_ff;
   logic [7:0] in_gradient_ff;
   logic [7:0] in_distance_ff;
   logic       out_vld_ff, out_vld_in;
   logic       out_take;
   logic       advance;
   logic       req_take;

   assign out_take  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_take;
   assign req_stall = in_vld_ff && !out_take;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take)     in_vld_in = 1'b1;
      else if (advance) in_vld_in = 1'b0;

      out_vld_in = out_vld_ff;
      if (advance)       out_vld_in = 1'b1;
      else if (out_take) out_vld_in = 1'b0;
   end

   sgec_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sgec_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .item_go       (advance),
      .item_func     (in_func_ff),
      .item_gradient (in_gradient_ff),
      .item_distance (in_distance_ff),
      .result        (result),
      .moving        (core_moving)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff     <= req_func;
         in_gradient_ff <= req_neighbour_gradient;
         in_distance_ff <= req_distance_mm;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_gradient   = out_ff.gradient;
   assign rsp_moving     = out_ff.moving;
   assign rsp_motion_cmd = out_ff.motion_cmd;
   assign rsp_led_color  = out_ff.led_color;

   // moving mode is never left once entered
   `SGEC_ASSERT_NEXT(a_moving_sticky, core_moving, core_moving)
   // a silence stop always blanks the LED
   `SGEC_ASSERT_SAME(a_stop_led_off, rsp_valid && rsp_motion_cmd == CMD_STOP,
                     rsp_led_color == LED_OFF)
   // orbit commands only come out in moving mode
   `SGEC_ASSERT_SAME(a_orbit_moving, rsp_valid && (rsp_motion_cmd == CMD_FORWARD ||
                     rsp_motion_cmd == CMD_LEFT || rsp_motion_cmd == CMD_RIGHT), rsp_moving)
   // input side stalls only while holding a transaction
   `SGEC_ASSERT_SAME(a_stall_holds_item, req_stall, in_vld_ff && out_vld_ff)

endmodule

`default_nettype wire

### rtl/sgec_cfg.sv
// ----------------------------------------------------------------------------
// sgec_cfg
// Configuration register file written over the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgec_cfg
   import sgec_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output      cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IS_SEED:          cfg_in.is_seed          = csr_wdata[0];
            CSR_ROUND_LENGTH:     cfg_in.round_length     = csr_wdata;
            CSR_NEIGHBOUR_RANGE:  cfg_in.neighbour_range  = csr_wdata;
            CSR_NEAR_LIMIT:       cfg_in.near_limit       = csr_wdata;
            CSR_ORBIT_RADIUS:     cfg_in.orbit_radius     = csr_wdata;
            CSR_SILENCE_TIMEOUT:  cfg_in.silence_timeout  = csr_wdata[6:0];
            CSR_EDGE_ROUNDS:      cfg_in.edge_rounds      = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.is_seed          <= RST_IS_SEED;
         cfg_ff.round_length     <= RST_ROUND_LENGTH;
         cfg_ff.neighbour_range  <= RST_NEIGHBOUR_RANGE;
         cfg_ff.near_limit       <= RST_NEAR_LIMIT;
         cfg_ff.orbit_radius     <= RST_ORBIT_RADIUS;
         cfg_ff.silence_timeout  <= RST_SILENCE_TIMEOUT;
         cfg_ff.edge_rounds      <= RST_EDGE_ROUNDS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/sgec_core.sv
// ----------------------------------------------------------------------------
// sgec_core
// Node state and the single-pass update that produces one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module sgec_core
   import sgec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       item_go,
   input  wire logic       item_func,
   input  wire logic [7:0] item_gradient,
   input  wire logic [7:0] item_distance,
   output      result_type result,
   output      logic       moving
);

   state_type  state_ff;
   state_type  state_in;
   logic [7:0] count_inc;
   logic       silent;
   logic [2:0] cmd;

   assign moving = state_ff.moving;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      silent    = 1'b0;
      count_inc = state_ff.message_count + 8'd1;

      if (cfg.is_seed) begin
         state_in.own_gradient = 8'd0;
      end

      if (item_func == FUNC_MESSAGE) begin
         if (!cfg.is_seed) begin
            state_in.message_count = count_inc;
            state_in.silence_ticks = '0;
            if (item_distance <= cfg.neighbour_range) begin
               if (item_gradient < state_ff.min_gradient) begin
                  state_in.min_gradient = item_gradient;
               end
               if (item_gradient > state_ff.max_gradient) begin
                  state_in.max_gradient = item_gradient;
               end
            end
            if (item_distance < state_ff.nearest) begin
               state_in.nearest = item_distance;
            end
            // round end: recompute gradient from the round minimum
            if (count_inc >= cfg.round_length) begin
               state_in.message_count = '0;
               state_in.own_gradient  = (state_in.min_gradient != GRADIENT_MAX) ?
                                        state_in.min_gradient + 8'd1 : GRADIENT_MAX;
               if (state_in.own_gradient > state_in.max_gradient &&
                   state_ff.edge_count != EDGE_MAX) begin
                  state_in.edge_count = state_ff.edge_count + 8'd1;
               end
               state_in.min_gradient = GRADIENT_MAX;
               if (state_ff.moving) begin
                  cmd = orbit_cmd(state_in.nearest, cfg.near_limit, cfg.orbit_radius);
               end
               state_in.nearest = FAR_DISTANCE;
            end
         end
      end else begin
         if (state_ff.silence_ticks != SILENCE_MAX) begin
            state_in.silence_ticks = state_ff.silence_ticks + 7'd1;
         end
      end

      if (state_in.edge_count > cfg.edge_rounds) begin
         state_in.moving = 1'b1;
      end

      if (item_func == FUNC_TICK && state_in.silence_ticks > cfg.silence_timeout &&
          state_in.own_gradient != GRADIENT_MAX && !cfg.is_seed) begin
         cmd                   = CMD_STOP;
         silent                = 1'b1;
         state_in.own_gradient = state_in.own_gradient + 8'd1;
      end

      result.gradient   = state_in.own_gradient;
      result.moving     = state_in.moving;
      result.motion_cmd = cmd;
      result.led_color  = silent ? LED_OFF : gradient_color(state_in.own_gradient);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.message_count <= '0;
         state_ff.min_gradient  <= GRADIENT_MAX;
         state_ff.max_gradient  <= '0;
         state_ff.nearest       <= FAR_DISTANCE;
         state_ff.own_gradient  <= GRADIENT_MAX;
         state_ff.edge_count    <= '0;
         state_ff.moving        <= 1'b0;
         state_ff.silence_ticks <= '0;
      end else if (item_go) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
